### hdl/morse_character_encoder_top_macros.svh
// Assertion macros used by the Morse encoder RTL.
`ifndef MORSE_CHARACTER_ENCODER_TOP_MACROS_SVH
`define MORSE_CHARACTER_ENCODER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define MCE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define MCE_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MCE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/mce_pkg.sv
// Shared types, constants and code tables for the Morse encoder.
`timescale 1ns / 1ps

package mce_pkg;

    localparam int CHAR_W = 8;
    localparam int DOT_W  = 20;
    localparam int DUR_W  = 22;
    localparam int LEN_W  = 3;
    localparam int SYM_W  = 5;

    localparam logic [DOT_W-1:0]  DOT_RESET_US    = 20'd50000;
    localparam int                QUEUE_DEPTH_DEF = 2;

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;

    // What the sequencer does with a character.
    typedef enum logic [1:0] {
        KIND_OTHER,
        KIND_SPACE,
        KIND_SYMBOL
    } kind_t;

    // Element pattern: sym holds dashes as ones, first element at the MSB.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [SYM_W-1:0] sym;
    } pattern_t;

    // Classified character as it travels through the queue.
    typedef struct packed {
        kind_t            kind;
        logic [LEN_W-1:0] len;
        logic [SYM_W-1:0] sym;
    } desc_t;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MARK,
        ST_GAP,
        ST_TAIL
    } state_t;

    // Event length in dot units.
    typedef enum logic [1:0] {
        UNITS_1,
        UNITS_3,
        UNITS_4
    } units_t;

    // Left-align a raw pattern so that the first element sits at the MSB.
    function automatic pattern_t align_pattern(logic [LEN_W-1:0] len, logic [SYM_W-1:0] raw);
        pattern_t p;
        p.len = len;
        p.sym = raw << (LEN_W'(SYM_W) - len);
        return p;
    endfunction

    // Letters A through Z, indexed from A.
    function automatic pattern_t letter_pattern(logic [4:0] idx);
        pattern_t p;
        unique case (idx)
            5'd0:    p = align_pattern(3'd2, 5'h01);
            5'd1:    p = align_pattern(3'd4, 5'h08);
            5'd2:    p = align_pattern(3'd4, 5'h0A);
            5'd3:    p = align_pattern(3'd3, 5'h04);
            5'd4:    p = align_pattern(3'd1, 5'h00);
            5'd5:    p = align_pattern(3'd4, 5'h02);
            5'd6:    p = align_pattern(3'd3, 5'h06);
            5'd7:    p = align_pattern(3'd4, 5'h00);
            5'd8:    p = align_pattern(3'd2, 5'h00);
            5'd9:    p = align_pattern(3'd4, 5'h07);
            5'd10:   p = align_pattern(3'd3, 5'h05);
            5'd11:   p = align_pattern(3'd4, 5'h04);
            5'd12:   p = align_pattern(3'd2, 5'h03);
            5'd13:   p = align_pattern(3'd2, 5'h02);
            5'd14:   p = align_pattern(3'd3, 5'h07);
            5'd15:   p = align_pattern(3'd4, 5'h06);
            5'd16:   p = align_pattern(3'd4, 5'h0D);
            5'd17:   p = align_pattern(3'd3, 5'h02);
            5'd18:   p = align_pattern(3'd3, 5'h00);
            5'd19:   p = align_pattern(3'd1, 5'h01);
            5'd20:   p = align_pattern(3'd3, 5'h01);
            5'd21:   p = align_pattern(3'd4, 5'h01);
            5'd22:   p = align_pattern(3'd3, 5'h03);
            5'd23:   p = align_pattern(3'd4, 5'h09);
            5'd24:   p = align_pattern(3'd4, 5'h0B);
            5'd25:   p = align_pattern(3'd4, 5'h0C);
            default: p = align_pattern(3'd1, 5'h00);
        endcase
        return p;
    endfunction

    // Digits 0 through 9; all have five elements.
    function automatic pattern_t digit_pattern(logic [3:0] idx);
        pattern_t p;
        p.len = 3'd5;
        unique case (idx)
            4'd0:    p.sym = 5'h1F;
            4'd1:    p.sym = 5'h0F;
            4'd2:    p.sym = 5'h07;
            4'd3:    p.sym = 5'h03;
            4'd4:    p.sym = 5'h01;
            4'd5:    p.sym = 5'h00;
            4'd6:    p.sym = 5'h10;
            4'd7:    p.sym = 5'h18;
            4'd8:    p.sym = 5'h1C;
            4'd9:    p.sym = 5'h1E;
            default: p.sym = 5'h00;
        endcase
        return p;
    endfunction

endpackage

### hdl/mce_front.sv
// Front part: accepts characters and classifies them into queue entries.
`timescale 1ns / 1ps

module mce_front
(
    input  logic                        push,
    input  logic [mce_pkg::CHAR_W-1:0]  char_code,
    output logic                        full,
    input  mce_pkg::q_stat_t            q_stat,
    output logic                        q_wr,
    output mce_pkg::desc_t              q_desc
);
    import mce_pkg::*;

    logic [CHAR_W-1:0] letter_off;
    logic [CHAR_W-1:0] digit_off;
    pattern_t          letter_pat;
    pattern_t          digit_pat;

    // The input side is full exactly when the queue is.
    assign full = q_stat.full;
    assign q_wr = push && !q_stat.full;

    // Table lookups, indexed from the first code of each range.
    assign letter_off = char_code - CHAR_UPPER_A;
    assign digit_off  = char_code - CHAR_DIGIT_0;
    assign letter_pat = letter_pattern(letter_off[4:0]);
    assign digit_pat  = digit_pattern(digit_off[3:0]);

    // Classify the character.
    always_comb
    begin
        q_desc.kind = KIND_OTHER;
        q_desc.len  = letter_pat.len;
        q_desc.sym  = letter_pat.sym;
        if (char_code == CHAR_SPACE)
        begin
            q_desc.kind = KIND_SPACE;
        end
        else if (char_code >= CHAR_UPPER_A && char_code <= CHAR_UPPER_Z)
        begin
            q_desc.kind = KIND_SYMBOL;
        end
        else if (char_code >= CHAR_DIGIT_0 && char_code <= CHAR_DIGIT_9)
        begin
            q_desc.kind = KIND_SYMBOL;
            q_desc.len  = digit_pat.len;
            q_desc.sym  = digit_pat.sym;
        end
    end

endmodule

### hdl/mce_queue.sv
// Short queue of classified characters between the front and back parts.
`timescale 1ns / 1ps

module mce_queue
#(
    parameter int DEPTH = mce_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  mce_pkg::desc_t   wr_desc,
    input  logic             rd,
    output mce_pkg::desc_t   rd_desc,
    output mce_pkg::q_stat_t stat
);
    import mce_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_wr;
    logic              do_rd;

    assign stat.empty = (count_reg == CNT_W'(0));
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign do_wr      = wr && !stat.full;
    assign do_rd      = rd && !stat.empty;
    assign rd_desc    = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update with wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_desc;
        end
    end

endmodule

### hdl/mce_back.sv
// Back part: steps through a character's elements and emits key events.
`timescale 1ns / 1ps
`include "morse_character_encoder_top_macros.svh"

module mce_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mce_pkg::DOT_W-1:0]   cfg_dot_length_us,
    input  mce_pkg::q_stat_t            q_stat,
    input  mce_pkg::desc_t              q_desc,
    output logic                        q_rd,
    output logic                        empty,
    input  logic                        pop,
    output logic                        is_mark,
    output logic [mce_pkg::DUR_W-1:0]   duration_us,
    output logic                        last_of_run
);
    import mce_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [DOT_W-1:0]  dot_reg;
    logic [DOT_W-1:0]  dot_next;
    logic [LEN_W-1:0]  cnt_reg;
    logic [LEN_W-1:0]  cnt_next;
    logic [SYM_W-1:0]  sym_reg;
    logic [SYM_W-1:0]  sym_next;
    logic              tail4_reg;
    logic              tail4_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_mark_reg;
    logic              out_mark_next;
    logic [DUR_W-1:0]  out_dur_reg;
    logic [DUR_W-1:0]  out_dur_next;
    logic              out_last_reg;
    logic              out_last_next;

    logic              slot_free;
    logic              emit;
    logic              ev_mark;
    units_t            ev_units;
    logic              ev_last;
    logic [DUR_W-1:0]  dur_1;
    logic [DUR_W-1:0]  dur_3;
    logic [DUR_W-1:0]  dur_4;
    logic [DUR_W-1:0]  ev_dur;

    // The dot length register takes a write in any cycle.
    assign cfg_ready = 1'b1;
    assign dot_next  = (cfg_valid && cfg_ready) ? cfg_dot_length_us : dot_reg;

    // The output slot can take a new event when empty or being drained.
    assign slot_free = !out_valid_reg || pop;

    // Sequencer: load a character, then for a symbol its marks and gaps, then the tail silence.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sym_next   = sym_reg;
        tail4_next = tail4_reg;
        q_rd       = 1'b0;
        emit       = 1'b0;
        ev_mark    = 1'b0;
        ev_units   = UNITS_1;
        ev_last    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_rd       = 1'b1;
                    cnt_next   = q_desc.len;
                    sym_next   = q_desc.sym;
                    tail4_next = (q_desc.kind == KIND_SPACE);
                    state_next = (q_desc.kind == KIND_SYMBOL) ? ST_MARK : ST_TAIL;
                end
            end
            ST_MARK:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    ev_mark    = 1'b1;
                    ev_units   = sym_reg[SYM_W-1] ? UNITS_3 : UNITS_1;
                    sym_next   = sym_reg << 1;
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = (cnt_reg == LEN_W'(1)) ? ST_TAIL : ST_GAP;
                end
            end
            ST_GAP:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_MARK;
                end
            end
            ST_TAIL:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    ev_units   = tail4_reg ? UNITS_4 : UNITS_3;
                    ev_last    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Event duration from the dot length by shift and add.
    assign dur_1 = DUR_W'(dot_reg);
    assign dur_3 = (dur_1 << 1) + dur_1;
    assign dur_4 = dur_1 << 2;

    always_comb
    begin
        unique case (ev_units)
            UNITS_1: ev_dur = dur_1;
            UNITS_3: ev_dur = dur_3;
            UNITS_4: ev_dur = dur_4;
            default: ev_dur = dur_1;
        endcase
    end

    // Output slot next values.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_mark_next  = out_mark_reg;
        out_dur_next   = out_dur_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_mark_next  = ev_mark;
            out_dur_next   = ev_dur;
            out_last_next  = ev_last;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dot_reg       <= DOT_RESET_US;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dot_reg       <= dot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        sym_reg      <= sym_next;
        tail4_reg    <= tail4_next;
        out_mark_reg <= out_mark_next;
        out_dur_reg  <= out_dur_next;
        out_last_reg <= out_last_next;
    end

    assign empty       = !out_valid_reg;
    assign is_mark     = out_mark_reg;
    assign duration_us = out_dur_reg;
    assign last_of_run = out_last_reg;

    // A queue entry is taken only by an idle sequencer, and only if one is there.
    `MCE_ASSERT_SAME(a_rd_when_idle, clk, rst_n, q_rd, state_reg == ST_IDLE && !q_stat.empty)
    // A mark or a gap always has at least one element left to send.
    `MCE_ASSERT_SAME(a_mark_has_elem, clk, rst_n, state_reg == ST_MARK, cnt_reg != '0)
    `MCE_ASSERT_SAME(a_gap_has_elem, clk, rst_n, state_reg == ST_GAP, cnt_reg != '0)
    // The tail silence ends the run and leaves a last event waiting.
    `MCE_ASSERT_NEXT(a_tail_last, clk, rst_n, emit && state_reg == ST_TAIL,
                     out_valid_reg && out_last_reg && state_reg == ST_IDLE)

endmodule

### hdl/morse_character_encoder_top.sv
// Morse encoder top level: front classifier, character queue and event sequencer.
//
// Input channel: a character is transferred on push while full is low. It is
// classified at once and held in a short queue (QUEUE_DEPTH entries).
// Result channel: key events wait on is_mark, duration_us and last_of_run while
// empty is low; pop transfers the oldest one. last_of_run marks the end of a
// character's events.
// Configuration: cfg_dot_length_us is written when cfg_valid is high; cfg_ready
// is always high. Write it only while no character is in flight.
// Path: a character passes the queue and the sequencer into the output register.
// Throughput: the sequencer has a load step for each character and then emits
// its events (1 to 10 per character), one event per cycle while the output slot
// is free; it loads the next character only after the last event of this one.
// Stall: one event is held in the output register; while pop stays low the
// sequencer waits, the queue fills, and full rises.
// Reset: rst_n clears the queue and output slot and sets the dot length to
// 50000 us.
`timescale 1ns / 1ps

module morse_character_encoder_top
#(
    parameter int QUEUE_DEPTH = mce_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [mce_pkg::CHAR_W-1:0]  char_code,
    output logic                        empty,
    input  logic                        pop,
    output logic                        is_mark,
    output logic [mce_pkg::DUR_W-1:0]   duration_us,
    output logic                        last_of_run,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mce_pkg::DOT_W-1:0]   cfg_dot_length_us
);
    import mce_pkg::*;

    q_stat_t q_stat;
    desc_t   wr_desc;
    desc_t   rd_desc;
    logic    q_wr;
    logic    q_rd;

    // Front part.
    mce_front u_front
    (
        .push      (push),
        .char_code (char_code),
        .full      (full),
        .q_stat    (q_stat),
        .q_wr      (q_wr),
        .q_desc    (wr_desc)
    );

    // Queue between the two parts.
    mce_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_desc (wr_desc),
        .rd      (q_rd),
        .rd_desc (rd_desc),
        .stat    (q_stat)
    );

    // Back part.
    mce_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_dot_length_us (cfg_dot_length_us),
        .q_stat            (q_stat),
        .q_desc            (rd_desc),
        .q_rd              (q_rd),
        .empty             (empty),
        .pop               (pop),
        .is_mark           (is_mark),
        .duration_us       (duration_us),
        .last_of_run       (last_of_run)
    );

endmodule

### test/morse_character_encoder_checker.sv
// Checker for the Morse encoder: predicts key events per character and compares each transfer.
`timescale 1ns / 1ps

module morse_character_encoder_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic                        full,
    input  logic [mce_pkg::CHAR_W-1:0]  char_code,
    input  logic                        empty,
    input  logic                        pop,
    input  logic                        is_mark,
    input  logic [mce_pkg::DUR_W-1:0]   duration_us,
    input  logic                        last_of_run,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [mce_pkg::DOT_W-1:0]   cfg_dot_length_us,
    output int                          fail_count,
    output int                          events_pending
);
    import mce_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic             mark;
        logic [DUR_W-1:0] dur;
        logic             last;
    } key_event_t;

    key_event_t       key_events_due[$];
    logic [DOT_W-1:0] dot_us;
    key_event_t       seen_event;
    key_event_t       due_event;

    // Morse spelling of a character; empty for anything not in the table.
    function automatic string morse_spelling(input logic [CHAR_W-1:0] code);
        case (code)
            "A": return ".-";
            "B": return "-...";
            "C": return "-.-.";
            "D": return "-..";
            "E": return ".";
            "F": return "..-.";
            "G": return "--.";
            "H": return "....";
            "I": return "..";
            "J": return ".---";
            "K": return "-.-";
            "L": return ".-..";
            "M": return "--";
            "N": return "-.";
            "O": return "---";
            "P": return ".--.";
            "Q": return "--.-";
            "R": return ".-.";
            "S": return "...";
            "T": return "-";
            "U": return "..-";
            "V": return "...-";
            "W": return ".--";
            "X": return "-..-";
            "Y": return "-.--";
            "Z": return "--..";
            "0": return "-----";
            "1": return ".----";
            "2": return "..---";
            "3": return "...--";
            "4": return "....-";
            "5": return ".....";
            "6": return "-....";
            "7": return "--...";
            "8": return "---..";
            "9": return "----.";
            default: return "";
        endcase
    endfunction

    // One key event at the current dot length; the product is cut to the port width.
    function automatic key_event_t make_event(input logic mark, input int unsigned units,
                                              input logic last);
        key_event_t ev;
        ev.mark = mark;
        ev.dur  = DUR_W'(dot_us) * DUR_W'(units);
        ev.last = last;
        return ev;
    endfunction

    // Queue the events of one character: elements with one-unit gaps, then the
    // three-unit character gap. A space is a lone four-unit silence.
    task automatic queue_key_events(input logic [CHAR_W-1:0] code);
        string spelling;
        int    i;
        if (code == CHAR_SPACE)
        begin
            key_events_due.push_back(make_event(1'b0, 4, 1'b1));
        end
        else
        begin
            spelling = morse_spelling(code);
            for (i = 0; i < spelling.len(); i++)
            begin
                key_events_due.push_back(
                    make_event(1'b1, (spelling[i] == "-") ? 3 : 1, 1'b0));
                if (i + 1 < spelling.len())
                    key_events_due.push_back(make_event(1'b0, 1, 1'b0));
            end
            key_events_due.push_back(make_event(1'b0, 3, 1'b1));
        end
    endtask

    // Count a bad event and print the first few.
    task automatic note_mismatch(input bit none_due, input key_event_t want,
                                 input key_event_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            if (none_due)
                $display("%0t: event with nothing due: mark=%0b dur=%0d last=%0b",
                         $realtime, got.mark, got.dur, got.last);
            else
                $display("%0t: mismatch: expected m=%0b d=%0d l=%0b, got m=%0b d=%0d l=%0b",
                         $realtime, want.mark, want.dur, want.last,
                         got.mark, got.dur, got.last);
        end
    endtask

    // Watch configuration, character and event transfers at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_events_due.delete();
            dot_us = DOT_RESET_US;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                dot_us = cfg_dot_length_us;
            if (push && !full)
                queue_key_events(char_code);
            if (pop && !empty)
            begin
                seen_event.mark = is_mark;
                seen_event.dur  = duration_us;
                seen_event.last = last_of_run;
                if (key_events_due.size() == 0)
                begin
                    note_mismatch(1'b1, seen_event, seen_event);
                end
                else
                begin
                    due_event = key_events_due.pop_front();
                    if (seen_event !== due_event)
                        note_mismatch(1'b0, due_event, seen_event);
                end
            end
        end
        events_pending = key_events_due.size();
    end

endmodule

### test/morse_character_encoder_top_test.sv
// Testbench top for the Morse encoder: character stimulus, dot-length writes, stalling reader.
`timescale 1ns / 1ps

module morse_character_encoder_top_test;

    import mce_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int CHARS_PER_PHASE  = 44;
    localparam int SETTLE_CYCLES    = 4;
    localparam int DRAIN_CYCLES     = 20;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [CHAR_W-1:0]  char_code;
    logic               empty;
    logic               pop;
    logic               is_mark;
    logic [DUR_W-1:0]   duration_us;
    logic               last_of_run;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [DOT_W-1:0]   cfg_dot_length_us;

    int    fail_count;
    int    events_pending;
    int    cycle_count = 0;
    int    burst_left;
    int    pop_run;
    logic  pop_high;
    string directed_text;
    int    k;

    morse_character_encoder_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .char_code         (char_code),
        .empty             (empty),
        .pop               (pop),
        .is_mark           (is_mark),
        .duration_us       (duration_us),
        .last_of_run       (last_of_run),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_dot_length_us (cfg_dot_length_us)
    );

    morse_character_encoder_checker event_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .char_code         (char_code),
        .empty             (empty),
        .pop               (pop),
        .is_mark           (is_mark),
        .duration_us       (duration_us),
        .last_of_run       (last_of_run),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_dot_length_us (cfg_dot_length_us),
        .fail_count        (fail_count),
        .events_pending    (events_pending)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up if the run hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Reader: alternates runs of pops and stalls, with some long unbroken pop runs.
    initial
    begin
        pop      = 1'b0;
        pop_high = 1'b0;
        pop_run  = 0;
        forever
        begin
            @(negedge clk);
            if (pop_run == 0)
            begin
                pop_high = !pop_high;
                if (pop_high)
                    pop_run = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                          : $urandom_range(1, 10);
                else
                    pop_run = $urandom_range(1, 7);
            end
            pop_run--;
            pop <= pop_high;
        end
    end

    // Random character: mostly letters and digits, some spaces, the rest any code.
    function automatic logic [CHAR_W-1:0] pick_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return CHAR_W'(CHAR_UPPER_A + $urandom_range(0, 25));
        else if (roll < 65)
            return CHAR_W'(CHAR_DIGIT_0 + $urandom_range(0, 9));
        else if (roll < 80)
            return CHAR_SPACE;
        else
            return CHAR_W'($urandom_range(0, 255));
    endfunction

    // Send one character, starting a new burst after a random gap when the last one ran out.
    task automatic send_char(input logic [CHAR_W-1:0] code);
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        push      <= 1'b1;
        char_code <= code;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
        burst_left--;
    endtask

    // Wait until every expected event has been transferred, then a few cycles more.
    task automatic wait_idle();
        push <= 1'b0;
        burst_left = 0;
        wait (events_pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write the dot length while the block is idle.
    task automatic write_dot(input logic [DOT_W-1:0] value);
        wait_idle();
        cfg_valid         <= 1'b1;
        cfg_dot_length_us <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_char(pick_char());
    endtask

    // Main sequence: reset, directed characters, then random phases at several dot lengths.
    initial
    begin
        rst_n             = 1'b0;
        push              = 1'b0;
        char_code         = '0;
        cfg_valid         = 1'b0;
        cfg_dot_length_us = '0;
        burst_left        = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: one-element letters, long letters, digits, runs of spaces,
        // lowercase, punctuation, code zero and the top of the code range.
        directed_text = "ET AZ09 5QBY  ";
        for (k = 0; k < directed_text.len(); k++)
            send_char(directed_text[k]);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h7F);
        send_char(8'h80);
        send_char("a");
        send_char("z");
        send_char("@");
        send_char("[");
        send_char("/");
        send_char(":");

        // Random phases across the dot-length extremes and some random values.
        write_dot(20'd1);
        send_random(CHARS_PER_PHASE);
        write_dot(20'd1000000);
        send_random(CHARS_PER_PHASE);
        write_dot(20'hFFFFF);
        send_random(CHARS_PER_PHASE);
        write_dot(20'd0);
        send_random(CHARS_PER_PHASE);
        repeat (3)
        begin
            write_dot(DOT_W'($urandom));
            send_random(CHARS_PER_PHASE);
        end
        write_dot(DOT_RESET_US);
        send_random(CHARS_PER_PHASE);

        // Drain and give the verdict.
        push <= 1'b0;
        wait (events_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && events_pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/mce_pkg.sv
hdl/mce_front.sv
hdl/mce_queue.sv
hdl/mce_back.sv
hdl/morse_character_encoder_top.sv
test/morse_character_encoder_checker.sv
test/morse_character_encoder_top_test.sv
